// ===== rtl/core/bpfd_pkg.sv =====
// Shared widths, codes, types and the filter coefficient table of the band-pass
// fall detector. No dependencies; every other file of the block imports it.
package bpfd_pkg;

   localparam int TIME_BITS = 48;
   localparam int FRAC_BITS = 8;
   localparam int AXIS_BITS = 15;
   localparam int SUMSQ_BITS = 30;
   localparam int SQRT_BITS = SUMSQ_BITS + 1;
   localparam int ROOT_BITS = 15;
   localparam int X_BITS = ROOT_BITS + 1 + FRAC_BITS;
   localparam int Y_BITS = 32;
   localparam int NEG_BITS = Y_BITS + 1;
   localparam int OUT_BITS = 24;
   localparam int COEF_BITS = 17;
   localparam int COEF_FRAC = 16;
   localparam int MUL_B_BITS = 32;
   localparam int PROD_BITS = COEF_BITS + MUL_B_BITS;
   localparam int ACC_BITS = PROD_BITS + 4;
   localparam int ROUND_HALF = 1 << (COEF_FRAC - 1);
   localparam int MG_OFFSET = 1000;
   localparam int NUM_TAPS = 4;
   localparam int TAP_BITS = 2;
   localparam int SQUARE_COUNT = 3;
   localparam int TERM_COUNT = 2 * NUM_TAPS + 1;
   localparam int STEP_BITS = 4;

   localparam int LOWER_BITS = 13;
   localparam int UPPER_BITS = 14;
   localparam int MIN_BITS = 24;
   localparam int MAX_BITS = 24;
   localparam int HOLD_BITS = 26;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 26;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWER_TH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPPER_TH = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_TIME = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TIME = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TIME = CSR_INDEX_BITS'(4);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ARMED = 2'd1,
      PH_HOLD  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SQUARE,
      SEQ_ROOT_GO,
      SEQ_ROOT_WAIT,
      SEQ_FILTER,
      SEQ_ROUND,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic signed [LOWER_BITS-1:0] lower_threshold_mg;
      logic signed [UPPER_BITS-1:0] upper_threshold_mg;
      logic [MIN_BITS-1:0]          min_fall_time_us;
      logic [MAX_BITS-1:0]          max_fall_time_us;
      logic [HOLD_BITS-1:0]         hold_time_us;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lower_threshold_mg: LOWER_BITS'(-650),
      upper_threshold_mg: UPPER_BITS'(1100),
      min_fall_time_us:   MIN_BITS'(150),
      max_fall_time_us:   MAX_BITS'(600000),
      hold_time_us:       HOLD_BITS'(2000000)
   };

   typedef struct packed {
      logic                       fall_flag;
      logic [1:0]                 detector_state;
      logic signed [OUT_BITS-1:0] filtered_mg;
   } result_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
   } mac_ctrl_type;

   // term order: b0*x, then per tap b[k]*x[n-k] and -a[k]*y[n-k]
   function automatic logic signed [COEF_BITS-1:0] filter_coef(
      input logic [STEP_BITS-1:0] step
   );
      logic signed [COEF_BITS-1:0] coef;
      case (step)
         4'd0:    coef = COEF_BITS'(13538);
         4'd1:    coef = COEF_BITS'(0);
         4'd2:    coef = COEF_BITS'(59315);
         4'd3:    coef = COEF_BITS'(-27076);
         4'd4:    coef = COEF_BITS'(-39184);
         4'd5:    coef = COEF_BITS'(0);
         4'd6:    coef = COEF_BITS'(19054);
         4'd7:    coef = COEF_BITS'(13538);
         4'd8:    coef = COEF_BITS'(-12833);
         default: coef = COEF_BITS'(0);
      endcase
      return coef;
   endfunction

endpackage

// ===== rtl/core/bpfd_if.sv =====
// Valid/ready channel interfaces of the band-pass fall detector: sample in,
// result out and register writes. Depends on bpfd_pkg for field widths.
interface bpfd_req_if import bpfd_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [AXIS_BITS-1:0] accel_x_mg;
   logic signed [AXIS_BITS-1:0] accel_y_mg;
   logic signed [AXIS_BITS-1:0] accel_z_mg;
   logic [TIME_BITS-1:0]        sample_time_us;

   modport source (output valid, accel_x_mg, accel_y_mg, accel_z_mg, sample_time_us,
                   input ready);
   modport sink (input valid, accel_x_mg, accel_y_mg, accel_z_mg, sample_time_us,
                 output ready);
endinterface

interface bpfd_rsp_if import bpfd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       fall_flag;
   logic [1:0]                 detector_state;
   logic signed [OUT_BITS-1:0] filtered_mg;

   modport source (output valid, fall_flag, detector_state, filtered_mg, input ready);
   modport sink (input valid, fall_flag, detector_state, filtered_mg, output ready);
endinterface

interface bpfd_csr_if import bpfd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bpfd_mac.sv =====
// Shared 17x32 signed multiply-accumulate unit with a registered product.
// Used for the sum of squares and for all filter terms. Depends on bpfd_pkg.
module bpfd_mac import bpfd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  mac_ctrl_type                 ctrl,
   input  logic signed [COEF_BITS-1:0]  op_a,
   input  logic signed [MUL_B_BITS-1:0] op_b,
   output logic signed [ACC_BITS-1:0]   acc
);

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        prod_vld_ff, prod_vld_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in = op_a * op_b;
      prod_vld_in = ctrl.mul_en;
      // the product is registered before it is added into the accumulator
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/core/bpfd_sqrt.sv =====
// Restoring integer square root, one result bit per cycle.
// Depends on bpfd_pkg for widths.
module bpfd_sqrt import bpfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUMSQ_BITS-1:0] radicand,
   output logic [ROOT_BITS-1:0]  root,
   output logic                  done
);

   logic [SUMSQ_BITS-1:0] rem_ff, rem_in;
   logic [SQRT_BITS-1:0]  root_ff, root_in;
   logic [SQRT_BITS-1:0]  bit_ff, bit_in;
   logic                  done_ff, done_in;
   logic [SQRT_BITS-1:0]  trial;
   logic                  fits;

   always_comb begin
      trial = root_ff + bit_ff;
      fits = {1'b0, rem_ff} >= trial;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = radicand;
         root_in = '0;
         bit_in = SQRT_BITS'(1) << (SQRT_BITS - 1);
      end else if (bit_ff != '0) begin
         if (fits) begin
            rem_in = rem_ff - trial[SUMSQ_BITS-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         done_in = (bit_ff == SQRT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff[ROOT_BITS-1:0];
   assign done = done_ff;

endmodule

// ===== rtl/core/bpfd_detect.sv =====
// Detector phase machine: idle, armed, fall hold, driven by the negated filter
// output and sample timestamps. Builds the result fields. Depends on bpfd_pkg.
module bpfd_detect import bpfd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      commit,
   input  logic signed [Y_BITS-1:0]  filt_y,
   input  logic [TIME_BITS-1:0]      sample_time,
   input  cfg_type                   cfg,
   output result_type                result
);

   phase_type                   phase_ff, phase_in;
   logic [TIME_BITS-1:0]        arm_time_ff, arm_time_in;
   logic [TIME_BITS-1:0]        hold_start_ff, hold_start_in;
   logic [TIME_BITS-1:0]        base_time;
   logic [TIME_BITS-1:0]        elapsed;
   logic signed [NEG_BITS-1:0]  neg;
   logic signed [NEG_BITS-1:0]  lo_th;
   logic signed [NEG_BITS-1:0]  up_th;
   logic                        lo_hit;
   logic                        up_hit;
   logic [NEG_BITS-OUT_BITS:0]  neg_top;

   always_comb begin
      neg = -(NEG_BITS'(filt_y));
      lo_th = NEG_BITS'($signed(cfg.lower_threshold_mg)) <<< FRAC_BITS;
      up_th = NEG_BITS'($signed(cfg.upper_threshold_mg)) <<< FRAC_BITS;
      lo_hit = neg > lo_th;
      up_hit = neg > up_th;
      base_time = (phase_ff == PH_HOLD) ? hold_start_ff : arm_time_ff;
      // wraps modulo the timestamp width
      elapsed = sample_time - base_time;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      arm_time_in = arm_time_ff;
      hold_start_in = hold_start_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (lo_hit) begin
               phase_in = PH_ARMED;
               arm_time_in = sample_time;
            end
         end
         PH_ARMED: begin
            if (up_hit) begin
               if (elapsed >= TIME_BITS'(cfg.min_fall_time_us)) begin
                  phase_in = PH_HOLD;
                  hold_start_in = sample_time;
               end
            end else if (elapsed > TIME_BITS'(cfg.max_fall_time_us)) begin
               phase_in = PH_IDLE;
            end
         end
         PH_HOLD: begin
            if (elapsed >= TIME_BITS'(cfg.hold_time_us)) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // result fields
   always_comb begin
      neg_top = neg[NEG_BITS-1:OUT_BITS-1];
      result.fall_flag = (phase_in == PH_HOLD);
      result.detector_state = phase_in;
      if ((&neg_top) || !(|neg_top)) begin
         result.filtered_mg = neg[OUT_BITS-1:0];
      end else if (neg[NEG_BITS-1]) begin
         result.filtered_mg = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         result.filtered_mg = {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         arm_time_ff <= '0;
         hold_start_ff <= '0;
      end else if (commit) begin
         phase_ff <= phase_in;
         arm_time_ff <= arm_time_in;
         hold_start_ff <= hold_start_in;
      end
   end

endmodule

// ===== rtl/core/accel_bandpass_fall_detector_core.sv =====
// Band-pass fall detector: each sample transfer produces exactly one result
// transfer. A sample is worked through in order, and the block takes no new
// sample until it is done: 3 squares on the shared 17x32 multiply-accumulate
// unit, a 16-step square root with its start and done, 9 filter terms on the
// same multiply-accumulate unit, then rounding and the phase decision. The
// result sits in an output register, so the next sample is taken while it
// waits; only a result still untaken when the following one finishes holds
// the block. Registers may be written at any time the block is idle. Depends
// on bpfd_pkg, bpfd_if, bpfd_mac, bpfd_sqrt and bpfd_detect.
module accel_bandpass_fall_detector_core import bpfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bpfd_req_if.sink   req_bus,
   bpfd_rsp_if.source rsp_bus,
   bpfd_csr_if.sink   csr_bus
);

   seq_state_type               state_ff, state_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   cfg_type                     cfg_ff, cfg_in;
   logic signed [AXIS_BITS-1:0] ax_ff, ay_ff, az_ff;
   logic [TIME_BITS-1:0]        time_ff;
   logic signed [X_BITS-1:0]    x_ff, x_in;
   logic signed [Y_BITS-1:0]    y_ff, y_in;
   logic signed [X_BITS-1:0]    in_hist_ff [NUM_TAPS];
   logic signed [Y_BITS-1:0]    out_hist_ff [NUM_TAPS];
   result_type                  rsp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_ready;
   logic                        req_take;
   logic                        csr_take;
   logic                        slot_free;
   logic                        commit;
   mac_ctrl_type                mac_ctrl;
   logic signed [COEF_BITS-1:0] op_a;
   logic signed [MUL_B_BITS-1:0] op_b;
   logic signed [ACC_BITS-1:0]  acc;
   logic                        sqrt_start;
   logic                        sqrt_done;
   logic [ROOT_BITS-1:0]        sqrt_root;
   logic signed [AXIS_BITS-1:0] axis_sel;
   logic [TAP_BITS-1:0]         odd_idx;
   logic [TAP_BITS-1:0]         even_idx;
   logic signed [ROOT_BITS:0]   root_diff;
   logic signed [ACC_BITS-1:0]  rounded;
   logic signed [ACC_BITS-1:0]  shifted;
   logic [ACC_BITS-Y_BITS:0]    shifted_top;
   result_type                  det_result;

   assign req_take = req_bus.valid && req_ready;
   assign csr_take = csr_bus.valid;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.fall_flag = rsp_ff.fall_flag;
   assign rsp_bus.detector_state = rsp_ff.detector_state;
   assign rsp_bus.filtered_mg = rsp_ff.filtered_mg;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         case (csr_bus.index)
            CSR_LOWER_TH:  cfg_in.lower_threshold_mg = csr_bus.data[LOWER_BITS-1:0];
            CSR_UPPER_TH:  cfg_in.upper_threshold_mg = csr_bus.data[UPPER_BITS-1:0];
            CSR_MIN_TIME:  cfg_in.min_fall_time_us = csr_bus.data[MIN_BITS-1:0];
            CSR_MAX_TIME:  cfg_in.max_fall_time_us = csr_bus.data[MAX_BITS-1:0];
            CSR_HOLD_TIME: cfg_in.hold_time_us = csr_bus.data[HOLD_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            step_in = '0;
            if (req_take) begin
               state_in = SEQ_SQUARE;
            end
         end
         SEQ_SQUARE: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SQUARE_COUNT)) begin
               state_in = SEQ_ROOT_GO;
               step_in = '0;
            end
         end
         SEQ_ROOT_GO: state_in = SEQ_ROOT_WAIT;
         SEQ_ROOT_WAIT: begin
            if (sqrt_done) begin
               state_in = SEQ_FILTER;
               step_in = '0;
            end
         end
         SEQ_FILTER: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(TERM_COUNT)) begin
               state_in = SEQ_ROUND;
               step_in = '0;
            end
         end
         SEQ_ROUND: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (slot_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mac_ctrl = '0;
      sqrt_start = 1'b0;
      commit = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         SEQ_SQUARE: mac_ctrl.mul_en = step_ff < STEP_BITS'(SQUARE_COUNT);
         SEQ_ROOT_GO: begin
            sqrt_start = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         SEQ_FILTER: mac_ctrl.mul_en = step_ff < STEP_BITS'(TERM_COUNT);
         SEQ_DONE: commit = slot_free;
         default: commit = 1'b0;
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      odd_idx = step_ff[TAP_BITS:1];
      even_idx = TAP_BITS'(step_ff[STEP_BITS-1:1] - 3'd1);
      case (step_ff[1:0])
         2'd0:    axis_sel = ax_ff;
         2'd1:    axis_sel = ay_ff;
         default: axis_sel = az_ff;
      endcase
      if (state_ff == SEQ_SQUARE) begin
         op_a = COEF_BITS'(axis_sel);
         op_b = MUL_B_BITS'(axis_sel);
      end else begin
         op_a = filter_coef(step_ff);
         if (step_ff == '0) begin
            op_b = MUL_B_BITS'(x_ff);
         end else if (step_ff[0]) begin
            op_b = MUL_B_BITS'(in_hist_ff[odd_idx]);
         end else begin
            op_b = MUL_B_BITS'(out_hist_ff[even_idx]);
         end
      end
   end

   // magnitude minus 1 g, then round and saturate the filter sum
   always_comb begin
      root_diff = $signed({1'b0, sqrt_root}) - $signed((ROOT_BITS + 1)'(MG_OFFSET));
      x_in = {root_diff, {FRAC_BITS{1'b0}}};
      rounded = acc + $signed(ACC_BITS'(ROUND_HALF));
      shifted = rounded >>> COEF_FRAC;
      shifted_top = shifted[ACC_BITS-1:Y_BITS-1];
      if ((&shifted_top) || !(|shifted_top)) begin
         y_in = shifted[Y_BITS-1:0];
      end else if (shifted[ACC_BITS-1]) begin
         y_in = {1'b1, {(Y_BITS-1){1'b0}}};
      end else begin
         y_in = {1'b0, {(Y_BITS-1){1'b1}}};
      end
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff <= '0;
         cfg_ff <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TAPS; i++) begin
            in_hist_ff[i] <= '0;
            out_hist_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            for (int i = NUM_TAPS - 1; i > 0; i--) begin
               in_hist_ff[i] <= in_hist_ff[i-1];
               out_hist_ff[i] <= out_hist_ff[i-1];
            end
            in_hist_ff[0] <= x_ff;
            out_hist_ff[0] <= y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ax_ff <= req_bus.accel_x_mg;
         ay_ff <= req_bus.accel_y_mg;
         az_ff <= req_bus.accel_z_mg;
         time_ff <= req_bus.sample_time_us;
      end
      if (state_ff == SEQ_ROOT_WAIT && sqrt_done) begin
         x_ff <= x_in;
      end
      if (state_ff == SEQ_ROUND) begin
         y_ff <= y_in;
      end
      if (commit) begin
         rsp_ff <= det_result;
      end
   end

   bpfd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   bpfd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc[SUMSQ_BITS-1:0]),
      .root     (sqrt_root),
      .done     (sqrt_done)
   );

   bpfd_detect u_detect (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .filt_y      (y_ff),
      .sample_time (time_ff),
      .cfg         (cfg_ff),
      .result      (det_result)
   );

endmodule

// ===== rtl/core/bpfd_checker.sv =====
// Port-level checks of the band-pass fall detector and the bind that attaches
// them to the top level. Depends on bpfd_pkg and the top level's interfaces.
module bpfd_checker import bpfd_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_fall_flag,
   input logic [1:0]                 rsp_detector_state,
   input logic signed [OUT_BITS-1:0] rsp_filtered_mg
);

   localparam logic [1:0] MAX_OUTSTANDING = 2'd2;

   logic [1:0] outstanding_ff, outstanding_in;
   logic [1:0] last_state_ff, last_state_in;
   logic       in_xfer;
   logic       out_xfer;

   assign in_xfer = req_valid && req_ready;
   assign out_xfer = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff + {1'b0, in_xfer} - {1'b0, out_xfer};
      last_state_in = out_xfer ? rsp_detector_state : last_state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         last_state_ff <= PH_IDLE;
      end else begin
         outstanding_ff <= outstanding_in;
         last_state_ff <= last_state_in;
      end
   end

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_mg)
         && $stable(rsp_detector_state) && $stable(rsp_fall_flag))
      else $error("result changed while stalled");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fall_flag == (rsp_detector_state == PH_HOLD)))
      else $error("fall flag disagrees with detector state");

   a_no_skip: assert property (@(posedge clock) disable iff (reset)
      out_xfer && (last_state_ff == PH_IDLE) |-> (rsp_detector_state != PH_HOLD))
      else $error("idle jumped straight to fall hold");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != 2'd0))
      else $error("result without an outstanding sample");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= MAX_OUTSTANDING)
      else $error("too many samples in flight");

endmodule

bind accel_bandpass_fall_detector_core bpfd_checker u_bpfd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_fall_flag      (rsp_bus.fall_flag),
   .rsp_detector_state (rsp_bus.detector_state),
   .rsp_filtered_mg    (rsp_bus.filtered_mg)
);

// ===== dv/accel_bandpass_fall_detector_core_test.sv =====
// Self-checking bench for the band-pass fall detector core: directed and random samples,
// register writes between phases, result checking against its own detector predictor.
// Depends on bpfd_pkg, the bpfd channel interfaces and the core RTL.
module accel_bandpass_fall_detector_core_test;
   import bpfd_pkg::*;

   localparam int     RESET_CYCLES    = 12;
   localparam int     PHASE_COUNT     = 8;
   localparam int     PHASE_SAMPLES   = 250;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     SETTLE_CYCLES   = 80;
   localparam longint TIMEOUT_UNITS   = 40_000_000;
   localparam longint ROUND_BIAS      = 32768;
   localparam longint Y_MAX   = (longint'(1) << (Y_BITS - 1)) - 1;
   localparam longint Y_MIN   = -Y_MAX - 1;
   localparam longint OUT_MAX = (longint'(1) << (OUT_BITS - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;
   localparam longint FEED_FWD [5] = '{13538, 0, -27076, 0, 13538};
   localparam longint FEEDBACK [5] = '{65536, -59315, 39184, -19054, 12833};
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = CSR_HOLD_TIME + 1'b1;

   typedef struct packed {
      logic signed [AXIS_BITS-1:0] accel_x_mg;
      logic signed [AXIS_BITS-1:0] accel_y_mg;
      logic signed [AXIS_BITS-1:0] accel_z_mg;
      logic [TIME_BITS-1:0]        sample_time_us;
   } sample_type;

   typedef enum int {MOTION_REST, MOTION_DROP, MOTION_IMPACT, MOTION_WILD} motion_type;

   logic clock = 1'b0;
   logic reset;

   bpfd_req_if req_bus();
   bpfd_rsp_if rsp_bus();
   bpfd_csr_if csr_bus();

   accel_bandpass_fall_detector_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // detector predictor state and register copies
   longint               in_hist [NUM_TAPS];
   longint               out_hist [NUM_TAPS];
   phase_type            det_phase;
   logic [TIME_BITS-1:0] arm_time;
   logic [TIME_BITS-1:0] hold_start;
   longint               lower_mg;
   longint               upper_mg;
   logic [TIME_BITS-1:0] min_us;
   logic [TIME_BITS-1:0] max_us;
   logic [TIME_BITS-1:0] hold_us;

   sample_type           sample_backlog [$];
   result_type           result_due [$];
   sample_type           on_bus;
   result_type           want;
   logic [TIME_BITS-1:0] stamp_us;
   int unsigned          send_gap;
   int unsigned          take_gap;
   int unsigned          send_idle_pct;
   int unsigned          take_idle_pct;
   int unsigned          hold_off_left;
   logic                 hold_off_request;
   int                   mismatch_count;
   int                   samples_taken;
   int                   results_checked;
   int                   armed_results;
   int                   hold_results;
   int                   input_stall_cycles;
   int                   settings_used;

   function automatic int jitter(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int unsigned pick_gap(input int unsigned idle_pct);
      if ($urandom_range(99) >= idle_pct)
         return 0;
      if ($urandom_range(99) < 90)
         return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   function automatic void apply_reg_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_LOWER_TH:  lower_mg = longint'($signed(value[LOWER_BITS-1:0]));
         CSR_UPPER_TH:  upper_mg = longint'($signed(value[UPPER_BITS-1:0]));
         CSR_MIN_TIME:  min_us = TIME_BITS'(value[MIN_BITS-1:0]);
         CSR_MAX_TIME:  max_us = TIME_BITS'(value[MAX_BITS-1:0]);
         CSR_HOLD_TIME: hold_us = TIME_BITS'(value[HOLD_BITS-1:0]);
         default: ;
      endcase
   endfunction

   function automatic result_type predict_detector_result(input sample_type s);
      longint               ax, ay, az, sumsq, root, trial, x, acc, y, neg;
      logic [TIME_BITS-1:0] dt;
      result_type           r;
      ax = longint'($signed(s.accel_x_mg));
      ay = longint'($signed(s.accel_y_mg));
      az = longint'($signed(s.accel_z_mg));
      sumsq = ax * ax + ay * ay + az * az;
      root = 0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         trial = root + (longint'(1) << b);
         if (trial * trial <= sumsq)
            root = trial;
      end
      x = (root - MG_OFFSET) * (longint'(1) << FRAC_BITS);
      acc = FEED_FWD[0] * x;
      for (int k = 0; k < NUM_TAPS; k++)
         acc = acc + FEED_FWD[k+1] * in_hist[k] - FEEDBACK[k+1] * out_hist[k];
      y = (acc + ROUND_BIAS) >>> COEF_FRAC;
      if (y > Y_MAX) y = Y_MAX;
      if (y < Y_MIN) y = Y_MIN;
      for (int k = NUM_TAPS - 1; k > 0; k--) begin
         in_hist[k] = in_hist[k-1];
         out_hist[k] = out_hist[k-1];
      end
      in_hist[0] = x;
      out_hist[0] = y;
      neg = -y;
      case (det_phase)
         PH_IDLE: begin
            if (neg > lower_mg * (longint'(1) << FRAC_BITS)) begin
               arm_time = s.sample_time_us;
               det_phase = PH_ARMED;
            end
         end
         PH_ARMED: begin
            dt = s.sample_time_us - arm_time;
            if (neg > upper_mg * (longint'(1) << FRAC_BITS)) begin
               if (dt >= min_us) begin
                  hold_start = s.sample_time_us;
                  det_phase = PH_HOLD;
               end
            end else if (dt > max_us) begin
               det_phase = PH_IDLE;
            end
         end
         PH_HOLD: begin
            // filter keeps running; leave hold on timestamp distance alone
            dt = s.sample_time_us - hold_start;
            if (dt >= hold_us)
               det_phase = PH_IDLE;
         end
         default: det_phase = PH_IDLE;
      endcase
      if (neg > OUT_MAX) neg = OUT_MAX;
      if (neg < OUT_MIN) neg = OUT_MIN;
      r.fall_flag = (det_phase == PH_HOLD);
      r.detector_state = det_phase;
      r.filtered_mg = OUT_BITS'(neg);
      return r;
   endfunction

   function automatic sample_type make_motion(input motion_type kind,
                                              input logic [TIME_BITS-1:0] t);
      sample_type s;
      int         mag;
      s.sample_time_us = t;
      case (kind)
         MOTION_REST: begin
            s.accel_x_mg = AXIS_BITS'(jitter(60));
            s.accel_y_mg = AXIS_BITS'(jitter(60));
            s.accel_z_mg = AXIS_BITS'(($urandom_range(1) ? 1000 : -1000) + jitter(60));
         end
         MOTION_DROP: begin
            s.accel_x_mg = AXIS_BITS'(jitter(150));
            s.accel_y_mg = AXIS_BITS'(jitter(150));
            s.accel_z_mg = AXIS_BITS'(jitter(150));
         end
         MOTION_IMPACT: begin
            mag = int'($urandom_range(3000, 16383)) * ($urandom_range(1) ? 1 : -1);
            s.accel_x_mg = AXIS_BITS'(jitter(500));
            s.accel_y_mg = AXIS_BITS'(jitter(500));
            s.accel_z_mg = AXIS_BITS'(jitter(500));
            case ($urandom_range(2))
               0: s.accel_x_mg = AXIS_BITS'(mag);
               1: s.accel_y_mg = AXIS_BITS'(mag);
               default: s.accel_z_mg = AXIS_BITS'(mag);
            endcase
         end
         default: begin
            s.accel_x_mg = AXIS_BITS'($urandom);
            s.accel_y_mg = AXIS_BITS'($urandom);
            s.accel_z_mg = AXIS_BITS'($urandom);
         end
      endcase
      return s;
   endfunction

   task automatic push_sample(input int x, input int y, input int z,
                              input logic [TIME_BITS-1:0] t);
      sample_type s;
      s.accel_x_mg = AXIS_BITS'(x);
      s.accel_y_mg = AXIS_BITS'(y);
      s.accel_z_mg = AXIS_BITS'(z);
      s.sample_time_us = t;
      sample_backlog.push_back(s);
   endtask

   // rest, free fall, impact, rest; a few noise samples and broken timestamps mixed in
   task automatic queue_fall_session(output int added);
      motion_type  kinds [4];
      int          lens [4];
      int unsigned step, roll;
      kinds = '{MOTION_REST, MOTION_DROP, MOTION_IMPACT, MOTION_REST};
      lens[0] = $urandom_range(3, 12);
      lens[1] = $urandom_range(2, 10);
      lens[2] = $urandom_range(1, 3);
      lens[3] = $urandom_range(5, 40);
      case ($urandom_range(9))
         6, 7:    step = $urandom_range(1, 400);
         8:       step = $urandom_range(50000, 700000);
         9:       step = $urandom_range(0, 50);
         default: step = 20000;
      endcase
      added = 0;
      for (int seg = 0; seg < 4; seg++) begin
         for (int k = 0; k < lens[seg]; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               sample_backlog.push_back(make_motion(MOTION_WILD,
                                                    TIME_BITS'({$urandom, $urandom})));
            end else begin
               if (roll < 11)
                  stamp_us = stamp_us - TIME_BITS'($urandom_range(1, 100000));
               else
                  stamp_us = stamp_us + TIME_BITS'(step + $urandom_range(step / 10));
               sample_backlog.push_back(make_motion(kinds[seg], stamp_us));
            end
            added++;
         end
      end
   endtask

   task automatic fill_samples(input int target);
      int pushed;
      int added;
      pushed = 0;
      while (pushed < target) begin
         queue_fall_session(added);
         pushed += added;
      end
   endtask

   task automatic wait_drain();
      while (sample_backlog.size() != 0 || req_bus.valid || result_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      apply_reg_write(idx, value);
      csr_bus.valid <= 1'b0;
   endtask

   // upper data bits carry junk; only the field width counts
   task automatic write_settings(input int lo, input int up, input int mn, input int mx,
                                 input int hd);
      logic [CSR_DATA_BITS-1:0] d;
      d = CSR_DATA_BITS'($urandom);
      d[LOWER_BITS-1:0] = LOWER_BITS'(lo);
      write_reg(CSR_LOWER_TH, d);
      d = CSR_DATA_BITS'($urandom);
      d[UPPER_BITS-1:0] = UPPER_BITS'(up);
      write_reg(CSR_UPPER_TH, d);
      d = CSR_DATA_BITS'($urandom);
      d[MIN_BITS-1:0] = MIN_BITS'(mn);
      write_reg(CSR_MIN_TIME, d);
      d = CSR_DATA_BITS'($urandom);
      d[MAX_BITS-1:0] = MAX_BITS'(mx);
      write_reg(CSR_MAX_TIME, d);
      write_reg(CSR_HOLD_TIME, CSR_DATA_BITS'(hd));
      // index past the register file must change nothing
      write_reg(CSR_INDEX_BITS'(int'(CSR_SPARE_FIRST)
                + $urandom_range((2 ** CSR_INDEX_BITS) - 1 - int'(CSR_SPARE_FIRST))),
                CSR_DATA_BITS'($urandom));
      settings_used++;
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            result_due.push_back(predict_detector_result(on_bus));
            samples_taken++;
         end
         if (req_bus.valid && !req_bus.ready)
            input_stall_cycles++;
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               on_bus = sample_backlog.pop_front();
               req_bus.accel_x_mg <= on_bus.accel_x_mg;
               req_bus.accel_y_mg <= on_bus.accel_y_mg;
               req_bus.accel_z_mg <= on_bus.accel_z_mg;
               req_bus.sample_time_us <= on_bus.sample_time_us;
               req_bus.valid <= 1'b1;
               send_gap = pick_gap(send_idle_pct);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted apart from the random stalls
   always @(posedge clock) begin
      if (reset)
         hold_off_left <= 0;
      else if (hold_off_left != 0)
         hold_off_left <= hold_off_left - 1;
      else if (hold_off_request)
         hold_off_left <= HOLD_OFF_CYCLES;
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (result_due.size() == 0) begin
               $display("%0t: result with none expected: flag %0b state %0d filtered %0d",
                        $time, rsp_bus.fall_flag, rsp_bus.detector_state,
                        rsp_bus.filtered_mg);
               mismatch_count++;
            end else begin
               want = result_due.pop_front();
               results_checked++;
               if (want.detector_state == PH_ARMED) armed_results++;
               if (want.detector_state == PH_HOLD) hold_results++;
               if (rsp_bus.fall_flag !== want.fall_flag) begin
                  $display("%0t: result %0d fall_flag expected %0b actual %0b", $time,
                           results_checked, want.fall_flag, rsp_bus.fall_flag);
                  mismatch_count++;
               end
               if (rsp_bus.detector_state !== want.detector_state) begin
                  $display("%0t: result %0d detector_state expected %0d actual %0d", $time,
                           results_checked, want.detector_state, rsp_bus.detector_state);
                  mismatch_count++;
               end
               if (rsp_bus.filtered_mg !== want.filtered_mg) begin
                  $display("%0t: result %0d filtered_mg expected %0d actual %0d", $time,
                           results_checked, want.filtered_mg, rsp_bus.filtered_mg);
                  mismatch_count++;
               end
            end
         end
         if (take_gap != 0)
            take_gap--;
         else
            take_gap = pick_gap(take_idle_pct);
         rsp_bus.ready <= (take_gap == 0) && (hold_off_left == 0);
      end
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("timeout with %0d results outstanding", result_due.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int                   p;
      logic [TIME_BITS-1:0] t;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.accel_x_mg = '0;
      req_bus.accel_y_mg = '0;
      req_bus.accel_z_mg = '0;
      req_bus.sample_time_us = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_LOWER_TH;
      csr_bus.data = '0;
      hold_off_request = 1'b0;
      send_idle_pct = 20;
      take_idle_pct = 20;
      mismatch_count = 0;
      samples_taken = 0;
      results_checked = 0;
      armed_results = 0;
      hold_results = 0;
      input_stall_cycles = 0;
      settings_used = 1;
      for (int k = 0; k < NUM_TAPS; k++) begin
         in_hist[k] = 0;
         out_hist[k] = 0;
      end
      det_phase = PH_IDLE;
      arm_time = '0;
      hold_start = '0;
      lower_mg = -650;
      upper_mg = 1100;
      min_us = 150;
      max_us = 600000;
      hold_us = 2000000;
      stamp_us = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: axis extremes, timestamp extremes and wrap, impacts, hold boundary
      push_sample(0, 0, 0, 0);
      push_sample(-16384, -16384, -16384, 20000);
      push_sample(16383, 16383, 16383, 40000);
      push_sample(-16384, 0, 0, 60000);
      push_sample(0, 16383, 0, 80000);
      push_sample(0, 0, -16384, 100000);
      push_sample(0, 0, 1000, 120000);
      push_sample(0, 0, 0, 48'hFFFF_FFFF_FFFF);
      push_sample(16383, 0, 0, 48'h0000_0000_0100);
      push_sample(0, 0, 0, 48'h0000_0000_0080);
      push_sample(-1, -1, -1, 48'hAAAA_AAAA_AAAA);
      push_sample(0, 0, 1000, 48'h5555_5555_5555);
      t = 48'h5555_5555_5555;
      for (int k = 0; k < 8; k++) begin
         t = t + 20000;
         if (k % 2 == 0)
            push_sample(16383, 0, 0, t);
         else
            push_sample(0, 0, 0, t);
      end
      t = t + 2000000;
      push_sample(0, 0, 1000, t);
      push_sample(0, 0, 1000, t + 1);
      wait_drain();

      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: write_settings(-4096, -8192, 0, 0, 0);
            1: write_settings(4095, 8191, 24'hFF_FFFF, 24'hFF_FFFF, 26'h3FF_FFFF);
            2: write_settings(-650, 1100, 150, 600000, 2000000);
            6: write_settings(int'($urandom), int'($urandom), int'($urandom),
                              int'($urandom), int'($urandom));
            default: write_settings(int'($urandom_range(1300)) - 1000,
                                    int'($urandom_range(2300)) + 200,
                                    $urandom_range(100000), $urandom_range(1000000),
                                    $urandom_range(3000000));
         endcase
         @(posedge clock);
         case (p)
            1: begin
               send_idle_pct <= 0;
               take_idle_pct <= 0;
            end
            4: begin
               send_idle_pct <= 0;
               take_idle_pct <= 20;
            end
            default: begin
               send_idle_pct <= $urandom_range(10, 40);
               take_idle_pct <= $urandom_range(10, 40);
            end
         endcase
         // timestamps run across the 48-bit wrap in this phase
         if (p == 5)
            stamp_us = '1 - TIME_BITS'($urandom_range(3000000));
         if (p == 2) begin
            fill_samples(PHASE_SAMPLES / 2);
            wait_drain();
            fill_samples(PHASE_SAMPLES / 2);
         end else begin
            fill_samples(PHASE_SAMPLES);
         end
         if (p == 4) begin
            @(posedge clock);
            hold_off_request <= 1'b1;
            @(posedge clock);
            hold_off_request <= 1'b0;
         end
         wait_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d samples sent, %0d checked under %0d register settings",
               samples_taken, results_checked, settings_used);
      $display("%0d results armed, %0d in fall hold, input held back for %0d cycles",
               armed_results, hold_results, input_stall_cycles);
      $display("%0d mismatches", mismatch_count);
      if (mismatch_count == 0 && result_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
